>>> src/hs3d_pkg.sv
package hs3d_pkg;

  // Grid limits and the shape of one plane store address.
  localparam int MAX_X      = 64;
  localparam int MAX_Y      = 64;
  localparam int MAX_Z      = 4096;
  localparam int X_BITS     = $clog2(MAX_X);
  localparam int Y_BITS     = $clog2(MAX_Y);
  localparam int Z_BITS     = $clog2(MAX_Z);
  localparam int ADDR_BITS  = 1 + Y_BITS + X_BITS;
  localparam int TEMP_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  // Configuration register indexes.
  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_HOT_X  = 3'd3;
  localparam logic [2:0] REG_HOT_Y  = 3'd4;
  localparam logic [2:0] REG_HOT_Z  = 3'd5;
  localparam logic [2:0] REG_COEFF  = 3'd6;

  // Item modes.
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] temp_in;
  } item_t;

  typedef struct packed {
    logic [15:0] temp_out;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [6:0]  size_x;
    logic [6:0]  size_y;
    logic [12:0] size_z;
    logic [5:0]  hot_x;
    logic [5:0]  hot_y;
    logic [11:0] hot_z;
    logic [15:0] diffusion_coeff;
  } cfg_t;

  // One unit of work passed from the front to the back.
  typedef struct packed {
    logic                 wr_en;
    logic                 has_result;
    logic                 cslot;
    logic [Y_BITS-1:0]    y;
    logic [X_BITS-1:0]    x;
    logic                 has_l;
    logic                 has_r;
    logic                 has_u;
    logic                 has_d;
    logic                 has_h;
    logic                 has_lower;
    logic                 is_source;
    logic                 last;
    logic [TEMP_BITS-1:0] lower;
  } job_t;

endpackage

>>> src/hs3d_bank.sv
module hs3d_bank (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [hs3d_pkg::ADDR_BITS-1:0] wr_addr,
  input  logic [hs3d_pkg::TEMP_BITS-1:0] wr_data,
  input  logic [hs3d_pkg::ADDR_BITS-1:0] rd_addr_a,
  input  logic [hs3d_pkg::ADDR_BITS-1:0] rd_addr_b,
  output logic [hs3d_pkg::TEMP_BITS-1:0] rd_data_a,
  output logic [hs3d_pkg::TEMP_BITS-1:0] rd_data_b
);
  import hs3d_pkg::*;

  logic [TEMP_BITS-1:0] mem [2**ADDR_BITS];

  // Two registered reads and one write; reads return the old contents.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> src/hs3d_queue.sv
module hs3d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            enq,
  input  hs3d_pkg::job_t  enq_job,
  input  logic            deq,
  output logic            full,
  output logic            valid,
  output hs3d_pkg::job_t  head
);
  import hs3d_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign full  = (count == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (!enq && deq) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wr_ptr] <= enq_job;
    end
  end

endmodule

>>> src/hs3d_front.sv
module hs3d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            restart,
  input  hs3d_pkg::cfg_t  cfg,
  input  logic            accept,
  input  hs3d_pkg::item_t item,
  output logic            enq,
  output hs3d_pkg::job_t  job
);
  import hs3d_pkg::*;

  logic [X_BITS-1:0] in_x;
  logic [Y_BITS-1:0] in_y;
  logic [Z_BITS-1:0] in_z;
  logic              flushing;

  logic [X_BITS:0]   sx;
  logic [Y_BITS:0]   sy;
  logic [Z_BITS:0]   sz;
  logic [Z_BITS-1:0] z_last;
  logic [Z_BITS-1:0] z_cell;
  logic              x_end;
  logic              y_end;
  logic              z_end;
  logic              is_drain;
  logic              take_cell;
  logic              take_drain;

  // Effective grid size: zero counts as one, large values clip to the maximum.
  always_comb begin
    if (cfg.size_x == '0) begin
      sx = (X_BITS+1)'(1);
    end else if (cfg.size_x > 7'(MAX_X)) begin
      sx = (X_BITS+1)'(MAX_X);
    end else begin
      sx = (X_BITS+1)'(cfg.size_x);
    end
    if (cfg.size_y == '0) begin
      sy = (Y_BITS+1)'(1);
    end else if (cfg.size_y > 7'(MAX_Y)) begin
      sy = (Y_BITS+1)'(MAX_Y);
    end else begin
      sy = (Y_BITS+1)'(cfg.size_y);
    end
    if (cfg.size_z == '0) begin
      sz = (Z_BITS+1)'(1);
    end else if (cfg.size_z > 13'(MAX_Z)) begin
      sz = (Z_BITS+1)'(MAX_Z);
    end else begin
      sz = (Z_BITS+1)'(cfg.size_z);
    end
  end

  assign z_last = Z_BITS'(sz - 1'b1);
  assign z_cell = in_z - 1'b1;
  assign x_end  = ({1'b0, in_x} + 1'b1 == sx);
  assign y_end  = ({1'b0, in_y} + 1'b1 == sy);
  assign z_end  = ({1'b0, in_z} + 1'b1 == sz);

  assign is_drain   = (item.mode == MODE_DRAIN);
  assign take_cell  = accept && !is_drain && !flushing;
  assign take_drain = accept && is_drain && flushing;
  assign enq        = take_cell || take_drain;

  // Classify the item: a cell item is a store write and an optional cell update, a drain item a cell update only.
  always_comb begin
    job.y     = in_y;
    job.x     = in_x;
    job.has_l = (in_x != '0);
    job.has_r = !x_end;
    job.has_u = (in_y != '0);
    job.has_d = !y_end;
    job.lower = item.temp_in;
    if (is_drain) begin
      job.wr_en      = 1'b0;
      job.has_result = 1'b1;
      job.cslot      = z_last[0];
      job.has_h      = (z_last != '0);
      job.has_lower  = 1'b0;
      job.is_source  = (in_x == cfg.hot_x) && (in_y == cfg.hot_y) &&
                       (z_last == cfg.hot_z);
      job.last       = x_end && y_end;
    end else begin
      job.wr_en      = 1'b1;
      job.has_result = (in_z != '0);
      job.cslot      = ~in_z[0];
      job.has_h      = (in_z > Z_BITS'(1));
      job.has_lower  = 1'b1;
      job.is_source  = (in_x == cfg.hot_x) && (in_y == cfg.hot_y) &&
                       (z_cell == cfg.hot_z);
      job.last       = 1'b0;
    end
  end

  // Raster position of the next cell, reused as the drain position while flushing.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_x     <= '0;
      in_y     <= '0;
      in_z     <= '0;
      flushing <= 1'b0;
    end else if (take_cell || take_drain) begin
      if (x_end) begin
        in_x <= '0;
        if (y_end) begin
          in_y <= '0;
          if (take_drain) begin
            flushing <= 1'b0;
          end else if (z_end) begin
            in_z     <= '0;
            flushing <= 1'b1;
          end else begin
            in_z <= in_z + 1'b1;
          end
        end else begin
          in_y <= in_y + 1'b1;
        end
      end else begin
        in_x <= in_x + 1'b1;
      end
    end
  end

endmodule

>>> src/hs3d_back.sv
module hs3d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       coeff,
  input  logic              job_valid,
  input  hs3d_pkg::job_t    job,
  output logic              job_take,
  output logic              empty,
  input  logic              pop,
  output hs3d_pkg::result_t result
);
  import hs3d_pkg::*;

  localparam int OPTR_BITS = $clog2(OUT_DEPTH);

  logic [ADDR_BITS-1:0] addr_c, addr_l, addr_r, addr_u, addr_d, addr_h;
  logic [TEMP_BITS-1:0] rd_c, rd_l, rd_r, rd_u, rd_d, rd_h;
  logic                 bank_we;

  logic                 s1_valid;
  job_t                 s1_job;
  logic [TEMP_BITS-1:0] n_l, n_r, n_u, n_d, n_h, n_lo;
  logic [18:0]          sum;
  logic [18:0]          six_c;

  logic                 s2_valid;
  logic signed [19:0]   s2_diff;
  logic [TEMP_BITS-1:0] s2_c;
  logic                 s2_src;
  logic                 s2_last;

  logic                 s3_valid;
  logic signed [36:0]   s3_prod;
  logic [TEMP_BITS-1:0] s3_c;
  logic                 s3_src;
  logic                 s3_last;

  logic signed [36:0]   rounded;
  logic signed [21:0]   sum_res;
  result_t              s3_result;

  result_t              out_buf [OUT_DEPTH];
  logic [OPTR_BITS-1:0] out_wr;
  logic [OPTR_BITS-1:0] out_rd;
  logic [OPTR_BITS:0]   out_count;
  logic [OPTR_BITS:0]   committed;
  logic                 out_push;
  logic                 out_pop;

  // Take a job only when the result buffer has room for everything in flight.
  assign committed = out_count + (OPTR_BITS+1)'(s1_valid) + (OPTR_BITS+1)'(s2_valid) +
                     (OPTR_BITS+1)'(s3_valid);
  assign job_take  = job_valid && (committed < (OPTR_BITS+1)'(OUT_DEPTH));
  assign bank_we   = job_take && job.wr_en;

  // Stencil addresses: centre plane slot, and the other slot for the upper neighbour.
  assign addr_c = {job.cslot, job.y, job.x};
  assign addr_l = {job.cslot, job.y, job.x - 1'b1};
  assign addr_r = {job.cslot, job.y, job.x + 1'b1};
  assign addr_u = {job.cslot, job.y - 1'b1, job.x};
  assign addr_d = {job.cslot, job.y + 1'b1, job.x};
  assign addr_h = {~job.cslot, job.y, job.x};

  // Three copies of the plane store, written together, two reads each.
  hs3d_bank u_bank_ch (
    .clk(clk), .wr_en(bank_we), .wr_addr(addr_h), .wr_data(job.lower),
    .rd_addr_a(addr_c), .rd_addr_b(addr_h), .rd_data_a(rd_c), .rd_data_b(rd_h)
  );
  hs3d_bank u_bank_lr (
    .clk(clk), .wr_en(bank_we), .wr_addr(addr_h), .wr_data(job.lower),
    .rd_addr_a(addr_l), .rd_addr_b(addr_r), .rd_data_a(rd_l), .rd_data_b(rd_r)
  );
  hs3d_bank u_bank_ud (
    .clk(clk), .wr_en(bank_we), .wr_addr(addr_h), .wr_data(job.lower),
    .rd_addr_a(addr_u), .rd_addr_b(addr_d), .rd_data_a(rd_u), .rd_data_b(rd_d)
  );

  // Neighbours outside the grid take the centre value.
  always_comb begin
    n_l   = s1_job.has_l ? rd_l : rd_c;
    n_r   = s1_job.has_r ? rd_r : rd_c;
    n_u   = s1_job.has_u ? rd_u : rd_c;
    n_d   = s1_job.has_d ? rd_d : rd_c;
    n_h   = s1_job.has_h ? rd_h : rd_c;
    n_lo  = s1_job.has_lower ? s1_job.lower : rd_c;
    sum   = 19'(n_l) + 19'(n_r) + 19'(n_u) + 19'(n_d) + 19'(n_h) + 19'(n_lo);
    six_c = {1'b0, rd_c, 2'b00} + {2'b00, rd_c, 1'b0};
  end

  // Round half up, add to the centre and saturate; the source cell keeps its centre value.
  always_comb begin
    rounded = s3_prod + 37'sd32768;
    sum_res = $signed({6'b0, s3_c}) + 22'(rounded >>> 16);
    if (s3_src) begin
      s3_result.temp_out = s3_c;
    end else if (sum_res < 0) begin
      s3_result.temp_out = '0;
    end else if (sum_res > 22'sd65535) begin
      s3_result.temp_out = '1;
    end else begin
      s3_result.temp_out = sum_res[15:0];
    end
    s3_result.last = s3_last;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= job_take && job.has_result;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Pipeline payload: stencil difference, then the single multiply.
  always_ff @(posedge clk) begin
    s1_job  <= job;
    s2_diff <= $signed({1'b0, sum}) - $signed({1'b0, six_c});
    s2_c    <= rd_c;
    s2_src  <= s1_job.is_source;
    s2_last <= s1_job.last;
    s3_prod <= $signed({1'b0, coeff}) * s2_diff;
    s3_c    <= s2_c;
    s3_src  <= s2_src;
    s3_last <= s2_last;
  end

  // Result buffer seen by the consumer as a queue.
  assign out_push = s3_valid;
  assign out_pop  = pop && !empty;
  assign empty    = (out_count == '0);
  assign result   = out_buf[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wr <= out_wr + 1'b1;
      end
      if (out_pop) begin
        out_rd <= out_rd + 1'b1;
      end
      if (out_push && !out_pop) begin
        out_count <= out_count + 1'b1;
      end else if (!out_push && out_pop) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_buf[out_wr] <= s3_result;
    end
  end

endmodule

>>> src/heat_stencil_3d_sweep.sv
// Seven-point 3D heat diffusion, one Jacobi time step per sweep. Cells enter in
// raster order (z, then y, then x) as unsigned Q9.7 temperatures; each cell of
// plane z yields the update of the cell at the same place in plane z-1, and once
// the whole grid is in, drain items give the final plane one result each, the
// last one marked. The block takes one item per clock while full is low; the
// rate is set by the plane store, three banks of two planes that each take one
// write and two reads per clock, and by the single multiply per cell. A
// configuration write to a known index restarts the sweep.
module heat_stencil_3d_sweep (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hs3d_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output hs3d_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import hs3d_pkg::*;

  cfg_t cfg;
  logic cfg_write;
  logic restart;
  logic accept;
  logic enq;
  job_t enq_job;
  logic q_valid;
  job_t q_head;
  logic q_take;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = push && !full;

  // Any known index restarts the sweep at the same edge as the write.
  assign restart   = cfg_write && (cfg_index <= REG_COEFF);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x          <= 7'd9;
      cfg.size_y          <= 7'd11;
      cfg.size_z          <= 13'd13;
      cfg.hot_x           <= 6'd2;
      cfg.hot_y           <= 6'd1;
      cfg.hot_z           <= 12'd6;
      cfg.diffusion_coeff <= 16'd6554;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SIZE_X: begin
            cfg.size_x <= cfg_data[6:0];
          end
          REG_SIZE_Y: begin
            cfg.size_y <= cfg_data[6:0];
          end
          REG_SIZE_Z: begin
            cfg.size_z <= cfg_data[12:0];
          end
          REG_HOT_X: begin
            cfg.hot_x <= cfg_data[5:0];
          end
          REG_HOT_Y: begin
            cfg.hot_y <= cfg_data[5:0];
          end
          REG_HOT_Z: begin
            cfg.hot_z <= cfg_data[11:0];
          end
          REG_COEFF: begin
            cfg.diffusion_coeff <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  hs3d_front u_front (
    .clk(clk), .rst(rst), .restart(restart), .cfg(cfg),
    .accept(accept), .item(item), .enq(enq), .job(enq_job)
  );

  hs3d_queue u_queue (
    .clk(clk), .rst(rst), .enq(enq), .enq_job(enq_job), .deq(q_take),
    .full(full), .valid(q_valid), .head(q_head)
  );

  hs3d_back u_back (
    .clk(clk), .rst(rst), .coeff(cfg.diffusion_coeff),
    .job_valid(q_valid), .job(q_head), .job_take(q_take),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule
